### hw/rtl/fbfba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbfba_pkg: shared types and constants of the block allocator
// Transfer payloads, status and register codes, chain and update flags.
// ----------------------------------------------------------------------------
package fbfba_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ADDR_W     = 32;
  localparam int REQ_W      = 24;
  localparam int HDR_W      = 7;
  localparam int STATUS_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd2;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RESET    = 32'h0000_0000;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET   = 32'hFFFF_FFFF;
  localparam logic [HDR_W-1:0]  HEADER_BYTES_RESET = 7'd24;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_FREE    = 1'b1;
  localparam logic PLACE_BEST = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

  typedef struct packed {
    logic              operation;
    logic [REQ_W-1:0]  request_size;
    logic              placement;
    logic [ADDR_W-1:0] block_address;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   data_address;
    logic [STATUS_W-1:0] status;
    logic                was_reused;
  } out_t;

  // search token travelling along the cell chain
  typedef struct packed {
    logic valid;
    logic found;
  } tok_t;

  // table update broadcast to every cell
  typedef struct packed {
    logic claim;
    logic release_blk;
    logic write;
  } upd_t;

endpackage

`default_nettype wire

### hw/rtl/fbfba_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbfba_cell: one table entry of the allocator chain
// Holds one block, folds it into the passing search token, applies updates.
// ----------------------------------------------------------------------------
module fbfba_cell #(
  parameter int IDX       = 0,
  parameter int IDX_W     = 6,
  parameter int CNT_W     = 7,
  parameter int SIZE_BITS = 24
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire  [CNT_W-1:0]              count,
  input  wire                           op,
  input  wire                           best,
  input  wire  [SIZE_BITS-1:0]          req_size,
  input  wire  [fbfba_pkg::ADDR_W-1:0]  addr,
  input  wire fbfba_pkg::tok_t          tok_in,
  input  wire  [IDX_W-1:0]              pick_idx_in,
  input  wire  [SIZE_BITS-1:0]          pick_size_in,
  input  wire  [fbfba_pkg::ADDR_W-1:0]  pick_start_in,
  output fbfba_pkg::tok_t               tok_out,
  output logic [IDX_W-1:0]              pick_idx_out,
  output logic [SIZE_BITS-1:0]          pick_size_out,
  output logic [fbfba_pkg::ADDR_W-1:0]  pick_start_out,
  input  wire fbfba_pkg::upd_t          upd,
  input  wire  [IDX_W-1:0]              upd_idx,
  input  wire  [SIZE_BITS-1:0]          upd_size,
  input  wire  [fbfba_pkg::ADDR_W-1:0]  upd_start
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

  logic [SIZE_BITS-1:0]         size_q;
  logic [fbfba_pkg::ADDR_W-1:0] start_q;
  logic                         free_q;
  logic                         found_q;
  logic                         valid_q;

  logic live;
  logic take_alloc;
  logic take_free;
  logic take;

  always_comb begin
    live       = MY_CNT < count;
    take_alloc = live && free_q && (size_q >= req_size) &&
                 (!tok_in.found || (best && (size_q < pick_size_in)));
    take_free  = live && !free_q && (start_q == addr) && !tok_in.found;
    take       = (op == fbfba_pkg::OP_FREE) ? take_free : take_alloc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_in.valid;
    end
  end

  // hold the token payload once it has passed
  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      found_q        <= tok_in.found || take;
      pick_idx_out   <= take ? MY_IDX : pick_idx_in;
      pick_size_out  <= take ? size_q : pick_size_in;
      pick_start_out <= take ? start_q : pick_start_in;
    end
  end

  assign tok_out = '{valid: valid_q, found: found_q};

  always_ff @(posedge clk) begin
    if (upd_idx == MY_IDX) begin
      if (upd.write) begin
        size_q  <= upd_size;
        start_q <= upd_start;
        free_q  <= 1'b0;
      end else if (upd.claim) begin
        free_q <= 1'b0;
      end else if (upd.release_blk) begin
        free_q <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/first_best_fit_block_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// first_best_fit_block_allocator_unit: first-fit / best-fit heap allocator
// Block table held in a chain of cells; a search token walks the chain.
//
//   port group   dir   transfer when
//   in_*         in    in_valid && !in_stall
//   out_*        out   out_valid && !out_stall
//   wr_*         in    wr_en (register write, no wait)
//
// Each item steps through accept, launch, the token crossing the chain cell
// by cell through the cell registers, then table update and result load.
// A new item is taken while the previous result still waits at the output.
// Reset clears the entry count and sets the break to the heap base; table
// contents need no clearing. A stalled output holds the next update.
// ----------------------------------------------------------------------------
module first_best_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS = 64,
  parameter int SIZE_BITS  = 24
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire fbfba_pkg::in_t              in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output fbfba_pkg::out_t                  out_data,
  input  wire                              wr_en,
  input  wire  [fbfba_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire  [fbfba_pkg::CFG_DATA_W-1:0] wr_data
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int AW     = fbfba_pkg::ADDR_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LAUNCH = 4'b0010,
    S_SCAN   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]           count;
  logic [AW-1:0]              brk;
  logic [AW-1:0]              heap_limit;
  logic [fbfba_pkg::HDR_W-1:0] header_bytes;

  logic                 op;
  logic                 best;
  logic [SIZE_BITS-1:0] req_size;
  logic [AW-1:0]        addr;
  logic [AW:0]          data_at;
  logic [AW+1:0]        new_break;

  logic [SIZE_BITS+fbfba_pkg::REQ_W-1:0] req_wide;

  fbfba_pkg::tok_t      tok_chain   [MAX_BLOCKS+1];
  logic [IDX_W-1:0]     idx_chain   [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0] size_chain  [MAX_BLOCKS+1];
  logic [AW-1:0]        start_chain [MAX_BLOCKS+1];

  fbfba_pkg::upd_t      upd;
  logic [IDX_W-1:0]     upd_idx;
  fbfba_pkg::out_t      res;

  logic accept;
  logic go;
  logic found;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign go       = !out_valid || !out_stall;
  assign found    = tok_chain[MAX_BLOCKS].found;
  assign req_wide = {{SIZE_BITS{1'b0}}, in_data.request_size};

  // chain head
  assign tok_chain[0]       = '{valid: (state == S_LAUNCH), found: 1'b0};
  assign idx_chain[0]       = '0;
  assign size_chain[0]      = '0;
  assign start_chain[0]     = '0;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    fbfba_cell #(
      .IDX       (g),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .count          (count),
      .op             (op),
      .best           (best),
      .req_size       (req_size),
      .addr           (addr),
      .tok_in         (tok_chain[g]),
      .pick_idx_in    (idx_chain[g]),
      .pick_size_in   (size_chain[g]),
      .pick_start_in  (start_chain[g]),
      .tok_out        (tok_chain[g+1]),
      .pick_idx_out   (idx_chain[g+1]),
      .pick_size_out  (size_chain[g+1]),
      .pick_start_out (start_chain[g+1]),
      .upd            (upd),
      .upd_idx        (upd_idx),
      .upd_size       (req_size),
      .upd_start      (data_at[AW-1:0])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_LAUNCH;
      end
      S_LAUNCH: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (tok_chain[MAX_BLOCKS].valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (go) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outcome of the scan
  always_comb begin
    upd              = '0;
    upd_idx          = idx_chain[MAX_BLOCKS];
    res.data_address = '0;
    res.status       = fbfba_pkg::ST_OK;
    res.was_reused   = 1'b0;
    if (op == fbfba_pkg::OP_FREE) begin
      if ((addr != '0) && found) begin
        upd.release_blk = 1'b1;
      end else begin
        res.status = fbfba_pkg::ST_IGNORED;
      end
    end else if (req_size == '0) begin
      res.status = fbfba_pkg::ST_ZERO;
    end else if (found) begin
      upd.claim        = 1'b1;
      res.data_address = start_chain[MAX_BLOCKS];
      res.was_reused   = 1'b1;
    end else if (new_break > {2'b00, heap_limit}) begin
      res.status = fbfba_pkg::ST_EXHAUSTED;
    end else if (count == CNT_FULL) begin
      res.status = fbfba_pkg::ST_FULL;
    end else begin
      upd.write        = 1'b1;
      upd_idx          = count[IDX_W-1:0];
      res.data_address = data_at[AW-1:0];
    end
    if (!((state == S_DECIDE) && go)) begin
      upd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      brk          <= fbfba_pkg::HEAP_BASE_RESET;
      heap_limit   <= fbfba_pkg::HEAP_LIMIT_RESET;
      header_bytes <= fbfba_pkg::HEADER_BYTES_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (upd.write) begin
        count <= count + CNT_W'(1);
        brk   <= new_break[AW-1:0];
      end
      if (wr_en) begin
        case (wr_index)
          fbfba_pkg::REG_HEAP_BASE: begin
            if (count == '0) brk <= wr_data[AW-1:0];
          end
          fbfba_pkg::REG_HEAP_LIMIT: begin
            heap_limit <= wr_data[AW-1:0];
          end
          fbfba_pkg::REG_HEADER_BYTES: begin
            header_bytes <= wr_data[fbfba_pkg::HDR_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if ((state == S_DECIDE) && go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= in_data.operation;
      best     <= (in_data.placement == fbfba_pkg::PLACE_BEST);
      req_size <= req_wide[SIZE_BITS-1:0];
      addr     <= in_data.block_address;
    end
    if (state == S_LAUNCH) begin
      data_at   <= {1'b0, brk} + (AW+1)'(header_bytes);
      new_break <= {2'b00, brk} + (AW+2)'(header_bytes) + (AW+2)'(req_size);
    end
    if ((state == S_DECIDE) && go) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

### sim/tb_first_best_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_first_best_fit_block_allocator_unit: self-checking bench of the allocator
// A queue-fed driver offers allocate and free requests. A predictor tracks the
// block table, the break and the registers, and queues one expected result per
// accepted request. A monitor compares each result transfer field by field.
// Phases change the registers while the block is idle and vary the sender and
// receiver idling. One phase holds off the receiver long enough to back up
// the input.
// ----------------------------------------------------------------------------
module tb_first_best_fit_block_allocator_unit;

  localparam int TABLE_DEPTH  = 64;
  localparam int SIZE_W       = 24;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam int HOLD_CYCLES  = 600;
  localparam int BATCH_LEN    = 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int AW           = fbfba_pkg::ADDR_W;
  localparam int RW           = fbfba_pkg::REQ_W;
  localparam int HW           = fbfba_pkg::HDR_W;
  localparam int IW           = fbfba_pkg::CFG_IDX_W;
  localparam int DW           = fbfba_pkg::CFG_DATA_W;

  localparam logic [IW-1:0] REG_UNUSED  = 2'd3;
  localparam logic          PLACE_FIRST = 1'b0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic            in_valid  = 1'b0;
  logic            in_stall;
  fbfba_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  fbfba_pkg::out_t out_data;
  logic            wr_en     = 1'b0;
  logic [IW-1:0]   wr_index  = '0;
  logic [DW-1:0]   wr_data   = '0;

  fbfba_pkg::in_t  pending_reqs[$];
  fbfba_pkg::out_t expected_results[$];
  logic [AW-1:0]   carved_addrs[$];
  fbfba_pkg::out_t want_result;

  logic [RW-1:0] tbl_size [TABLE_DEPTH];
  logic [AW-1:0] tbl_start[TABLE_DEPTH];
  logic          tbl_free [TABLE_DEPTH];
  int            tbl_count = 0;
  logic [AW-1:0] break_ptr = fbfba_pkg::HEAP_BASE_RESET;

  logic [AW-1:0] cfg_limit  = fbfba_pkg::HEAP_LIMIT_RESET;
  logic [HW-1:0] cfg_header = fbfba_pkg::HEADER_BYTES_RESET;

  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_arm      = 1'b0;
  int   hold_left     = 0;
  int   cycle_count   = 0;
  int   error_count   = 0;

  first_best_fit_block_allocator_unit #(
    .MAX_BLOCKS(TABLE_DEPTH),
    .SIZE_BITS (SIZE_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (error_count < 50) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
    error_count++;
  endtask

  function automatic fbfba_pkg::out_t predict_result(input fbfba_pkg::in_t req);
    fbfba_pkg::out_t res;
    int              pick;
    int              i;
    logic [33:0]     data_at;
    logic [33:0]     new_brk;
    logic [RW-1:0]   size;
    res  = '0;
    pick = -1;
    size = req.request_size;
    if (req.operation == fbfba_pkg::OP_FREE) begin
      res.status = fbfba_pkg::ST_IGNORED;
      if (req.block_address != '0) begin
        for (i = 0; i < tbl_count; i++) begin
          if (pick < 0 && !tbl_free[i] && tbl_start[i] == req.block_address) pick = i;
        end
      end
      if (pick >= 0) begin
        tbl_free[pick] = 1'b1;
        res.status = fbfba_pkg::ST_OK;
      end
    end else if (size == '0) begin
      res.status = fbfba_pkg::ST_ZERO;
    end else begin
      for (i = 0; i < tbl_count; i++) begin
        if (tbl_free[i] && tbl_size[i] >= size) begin
          if (req.placement == fbfba_pkg::PLACE_BEST) begin
            if (pick < 0 || tbl_size[i] < tbl_size[pick]) pick = i;
          end else if (pick < 0) begin
            pick = i;
          end
        end
      end
      if (pick >= 0) begin
        tbl_free[pick]   = 1'b0;
        res.data_address = tbl_start[pick];
        res.status       = fbfba_pkg::ST_OK;
        res.was_reused   = 1'b1;
      end else begin
        data_at = {2'b00, break_ptr} + {27'd0, cfg_header};
        new_brk = data_at + {10'd0, size};
        if (new_brk > {2'b00, cfg_limit}) begin
          res.status = fbfba_pkg::ST_EXHAUSTED;
        end else if (tbl_count >= TABLE_DEPTH) begin
          res.status = fbfba_pkg::ST_FULL;
        end else begin
          tbl_size[tbl_count]  = size;
          tbl_start[tbl_count] = data_at[AW-1:0];
          tbl_free[tbl_count]  = 1'b0;
          tbl_count++;
          break_ptr        = new_brk[AW-1:0];
          res.data_address = data_at[AW-1:0];
          res.status       = fbfba_pkg::ST_OK;
          carved_addrs.push_back(data_at[AW-1:0]);
        end
      end
    end
    return res;
  endfunction

  function automatic fbfba_pkg::in_t make_req(input logic op, input logic [RW-1:0] size,
                                              input logic place, input logic [AW-1:0] addr);
    fbfba_pkg::in_t req;
    req.operation     = op;
    req.request_size  = size;
    req.placement     = place;
    req.block_address = addr;
    return req;
  endfunction

  function automatic fbfba_pkg::in_t random_req();
    fbfba_pkg::in_t req;
    int             roll;
    roll              = $urandom_range(0, 99);
    req.operation     = (roll < 40) ? fbfba_pkg::OP_FREE : fbfba_pkg::OP_ALLOC;
    req.placement     = 1'($urandom_range(0, 1));
    req.block_address = $urandom;
    req.request_size  = RW'($urandom_range(1, 256));
    if (req.operation == fbfba_pkg::OP_FREE) begin
      roll = $urandom_range(0, 99);
      if (roll < 75 && carved_addrs.size() > 0) begin
        req.block_address = carved_addrs[$urandom_range(0, carved_addrs.size() - 1)];
      end else if (roll < 85) begin
        req.block_address = '0;
      end
      if ($urandom_range(0, 9) == 0) req.request_size = RW'($urandom);
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        req.request_size = '0;
      end else if (roll < 15) begin
        req.request_size = RW'($urandom);
      end
    end
    return req;
  endfunction

  // transfer in, predict on acceptance, offer the next pending request
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_result(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding");
      end else begin
        want_result = expected_results.pop_front();
        if (out_data.data_address !== want_result.data_address) begin
          report_mismatch($sformatf("data_address %h, want %h",
                                    out_data.data_address, want_result.data_address));
        end
        if (out_data.status !== want_result.status) begin
          report_mismatch($sformatf("status %0d, want %0d",
                                    out_data.status, want_result.status));
        end
        if (out_data.was_reused !== want_result.was_reused) begin
          report_mismatch($sformatf("was_reused %b, want %b",
                                    out_data.was_reused, want_result.was_reused));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] value);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    case (idx)
      fbfba_pkg::REG_HEAP_BASE: begin
        if (tbl_count == 0) break_ptr = value;
      end
      fbfba_pkg::REG_HEAP_LIMIT: begin
        cfg_limit = value;
      end
      fbfba_pkg::REG_HEADER_BYTES: begin
        cfg_header = value[HW-1:0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (!(pending_reqs.size() == 0 && !in_valid && expected_results.size() == 0));
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int busy_pct);
    int i;
    send_idle_pct = idle_pct;
    stall_pct     = busy_pct;
    for (i = 0; i < count; i++) begin
      if (i % BATCH_LEN == 0) begin
        while (pending_reqs.size() != 0) @(negedge clk);
      end
      pending_reqs.push_back(random_req());
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    write_reg(fbfba_pkg::REG_HEAP_BASE, 32'h0000_1000);
    write_reg(fbfba_pkg::REG_HEAP_LIMIT, 32'h0010_0000);
    write_reg(fbfba_pkg::REG_HEADER_BYTES, 32'd16);

    pending_reqs.push_back(make_req(fbfba_pkg::OP_ALLOC, '0, PLACE_FIRST, $urandom));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_ALLOC, 24'd100, PLACE_FIRST, $urandom));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_ALLOC, 24'd50, fbfba_pkg::PLACE_BEST,
                                    $urandom));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_ALLOC, 24'd200, PLACE_FIRST, $urandom));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_ALLOC, 24'd50, PLACE_FIRST, $urandom));
    wait_idle();

    // free out of order, then reuse by both placements
    pending_reqs.push_back(make_req(fbfba_pkg::OP_FREE, 24'hFF_FFFF, fbfba_pkg::PLACE_BEST,
                                    '0));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_FREE, '0, PLACE_FIRST, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_FREE, RW'($urandom), PLACE_FIRST,
                                    carved_addrs[1]));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_FREE, RW'($urandom), fbfba_pkg::PLACE_BEST,
                                    carved_addrs[3]));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_FREE, RW'($urandom), PLACE_FIRST,
                                    carved_addrs[2]));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_FREE, RW'($urandom), PLACE_FIRST,
                                    carved_addrs[1]));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_ALLOC, 24'd40, fbfba_pkg::PLACE_BEST,
                                    $urandom));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_ALLOC, 24'd40, PLACE_FIRST, $urandom));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_ALLOC, 24'd60, fbfba_pkg::PLACE_BEST,
                                    $urandom));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_ALLOC, 24'hFF_FFFF, fbfba_pkg::PLACE_BEST,
                                    $urandom));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_ALLOC, 24'd50, PLACE_FIRST, $urandom));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_FREE, RW'($urandom), fbfba_pkg::PLACE_BEST,
                                    carved_addrs[0]));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_ALLOC, 24'hFF_FFFF, PLACE_FIRST,
                                    32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(fbfba_pkg::OP_ALLOC, 24'd100, PLACE_FIRST, '0));
    wait_idle();

    write_reg(fbfba_pkg::REG_HEAP_LIMIT, fbfba_pkg::HEAP_LIMIT_RESET);
    write_reg(fbfba_pkg::REG_HEADER_BYTES, 32'd0);
    run_phase(96, 0, 0);

    write_reg(fbfba_pkg::REG_HEADER_BYTES, 32'd64);
    run_phase(256, 80, 0);

    write_reg(fbfba_pkg::REG_HEAP_LIMIT, break_ptr + 32'd2000);
    write_reg(fbfba_pkg::REG_HEADER_BYTES, 32'hFFFF_FF85);
    run_phase(300, 0, 80);

    write_reg(fbfba_pkg::REG_HEAP_LIMIT, 32'd0);
    write_reg(fbfba_pkg::REG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(fbfba_pkg::REG_HEADER_BYTES, 32'd127);
    run_phase(256, 24, 24);

    write_reg(fbfba_pkg::REG_HEAP_LIMIT, fbfba_pkg::HEAP_LIMIT_RESET);
    write_reg(fbfba_pkg::REG_HEADER_BYTES, {25'd0, fbfba_pkg::HEADER_BYTES_RESET});
    @(negedge clk);
    hold_arm = 1'b1;
    @(negedge clk);
    hold_arm = 1'b0;
    run_phase(300, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
